@@ rtl/evad_pkg.sv @@
// Types and constants shared by the energy voice activity detector.
package evad_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SQ_W      = 31;
    localparam int HOP_REG_W = 12;
    localparam int LIMIT_W   = 44;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HOP_SIZE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_LIMIT = 8'd1;

    localparam logic [HOP_REG_W-1:0] HOP_RESET   = 12'd200;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 44'd42949673;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } t_in_word;

    typedef struct packed {
        logic [OUT_W-1:0] segment_start;
        logic [OUT_W-1:0] segment_end;
    } t_out_word;

    typedef struct packed {
        logic vld;
        logic last;
        logic done;
        logic have_prev;
    } t_blk_ctl;

endpackage

@@ rtl/evad_blk_acc.sv @@
// Sample squaring and hop block energy accumulation.
module evad_blk_acc #(
    parameter int COUNT_BITS = 32,
    parameter int HOP_BITS   = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  evad_pkg::t_in_word                  i_in_word,
    input  logic [evad_pkg::HOP_REG_W-1:0]      i_hop,
    input  logic                                i_adv,
    output evad_pkg::t_blk_ctl                  o_ctl,
    output logic [evad_pkg::SQ_W+HOP_BITS-1:0]  o_blk_energy,
    output logic [COUNT_BITS-1:0]               o_blk_index,
    output logic [COUNT_BITS-1:0]               o_seen
);
    import evad_pkg::*;

    localparam int EW = SQ_W + HOP_BITS;
    localparam int HW = (HOP_BITS > HOP_REG_W) ? HOP_BITS : HOP_REG_W;

    logic                        en1;
    logic                        en2;
    logic                        fire2;
    logic signed [2*SAMPLE_W-1:0] sq_full;

    logic                r1_vld;
    logic [SQ_W-1:0]     r1_sq;
    logic                r1_last;

    logic [HOP_BITS-1:0]   r_pos;
    logic [EW-1:0]         r_cur;
    logic [COUNT_BITS-1:0] r_cb;
    logic [COUNT_BITS-1:0] r_seen;

    t_blk_ctl              r2_ctl;
    logic [EW-1:0]         r2_energy;
    logic [COUNT_BITS-1:0] r2_cb;
    logic [COUNT_BITS-1:0] r2_seen;

    logic [HOP_BITS-1:0]   n_pos;
    logic [EW-1:0]         n_acc;
    logic [COUNT_BITS-1:0] n_seen;
    logic                  n_done;

    assign en2        = !r2_ctl.vld || i_adv;
    assign en1        = !r1_vld || en2;
    assign fire2      = en2 && r1_vld;
    assign o_in_ready = en1;
    assign sq_full    = i_in_word.sample * i_in_word.sample;

    always_comb begin
        n_pos  = r_pos + HOP_BITS'(1);
        n_acc  = r_cur + EW'(r1_sq);
        n_seen = r_seen + COUNT_BITS'(1);
        n_done = (HW'(n_pos) >= HW'(i_hop)) || (n_pos == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en1) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r1_sq   <= sq_full[SQ_W-1:0];
            r1_last <= i_in_word.last_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
            r_pos  <= '0;
            r_cur  <= '0;
            r_cb   <= '0;
            r_seen <= '0;
        end else begin
            if (en2) begin
                r2_ctl.vld <= r1_vld;
            end
            if (fire2) begin
                r2_ctl.last      <= r1_last;
                r2_ctl.done      <= n_done;
                r2_ctl.have_prev <= (r_cb != '0);
                if (r1_last) begin
                    r_pos  <= '0;
                    r_cur  <= '0;
                    r_cb   <= '0;
                    r_seen <= '0;
                end else begin
                    r_pos  <= n_done ? '0 : n_pos;
                    r_cur  <= n_done ? '0 : n_acc;
                    r_cb   <= n_done ? r_cb + COUNT_BITS'(1) : r_cb;
                    r_seen <= n_seen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire2) begin
            r2_energy <= n_acc;
            r2_cb     <= r_cb;
            r2_seen   <= n_seen;
        end
    end

    assign o_ctl        = r2_ctl;
    assign o_blk_energy = r2_energy;
    assign o_blk_index  = r2_cb;
    assign o_seen       = r2_seen;

endmodule

@@ rtl/evad_seg.sv @@
// Frame energy decision, segment tracking and result register.
module evad_seg #(
    parameter int COUNT_BITS = 32,
    parameter int HOP_BITS   = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  evad_pkg::t_blk_ctl                  i_ctl,
    input  logic [evad_pkg::SQ_W+HOP_BITS-1:0]  i_blk_energy,
    input  logic [COUNT_BITS-1:0]               i_blk_index,
    input  logic [COUNT_BITS-1:0]               i_seen,
    input  logic [evad_pkg::HOP_REG_W-1:0]      i_hop,
    input  logic [evad_pkg::LIMIT_W-1:0]        i_limit,
    output logic                                o_adv,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output evad_pkg::t_out_word                 o_out_word
);
    import evad_pkg::*;

    localparam int EW = SQ_W + HOP_BITS;
    localparam int FW = (EW + 1 > LIMIT_W) ? EW + 1 : LIMIT_W;
    localparam int PW = COUNT_BITS + HOP_REG_W;
    localparam int XW = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

    logic                  fire;
    logic [FW-1:0]         frame;
    logic                  speech;
    logic [PW-1:0]         prod;
    logic [COUNT_BITS-1:0] fs;

    logic [EW-1:0]         r_prev;
    logic                  r_act;
    logic [COUNT_BITS-1:0] r_beg;
    logic                  r_out_vld;
    t_out_word             r_out_word;

    logic [EW-1:0]         n_prev;
    logic                  n_act;
    logic [COUNT_BITS-1:0] n_beg;
    logic                  n_emit;
    logic [COUNT_BITS-1:0] n_end_idx;
    logic [COUNT_BITS-1:0] n_beg_out;
    logic [XW-1:0]         beg_x;
    logic [XW-1:0]         end_x;

    assign o_adv  = !r_out_vld || i_out_ready;
    assign fire   = o_adv && i_ctl.vld;
    assign frame  = FW'(r_prev) + FW'(i_blk_energy);
    assign speech = frame >= FW'(i_limit);
    assign prod   = PW'(i_blk_index - COUNT_BITS'(1)) * PW'(i_hop);
    assign fs     = prod[COUNT_BITS-1:0];

    always_comb begin
        n_prev    = r_prev;
        n_act     = r_act;
        n_beg     = r_beg;
        n_emit    = 1'b0;
        n_beg_out = r_beg;
        n_end_idx = fs;
        if (i_ctl.done) begin
            if (i_ctl.have_prev) begin
                if (speech && !r_act) begin
                    n_beg = fs;
                    n_act = 1'b1;
                end else if (!speech && r_act) begin
                    n_emit = 1'b1;
                    n_act  = 1'b0;
                end
            end
            n_prev = i_blk_energy;
        end
        if (i_ctl.last) begin
            if (n_act && !n_emit) begin
                n_emit    = 1'b1;
                n_beg_out = n_beg;
                n_end_idx = i_seen;
            end
            n_prev = '0;
            n_act  = 1'b0;
            n_beg  = '0;
        end
    end

    assign beg_x = XW'(n_beg_out);
    assign end_x = XW'(n_end_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_act     <= 1'b0;
            r_beg     <= '0;
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            r_out_vld <= fire && n_emit;
            if (fire) begin
                r_prev <= n_prev;
                r_act  <= n_act;
                r_beg  <= n_beg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_emit) begin
            r_out_word.segment_start <= beg_x[OUT_W-1:0];
            r_out_word.segment_end   <= end_x[OUT_W-1:0];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/energy_voice_activity_detector_top.sv @@
// Energy voice activity detector top level: config registers and pipeline.
// A sample word passes the per-sample square register, the block accumulate register
// and the result register. Throughput: one sample word per cycle while the output is not
// stalled; the frame compare and start index multiply feed the result register.
// Reset (synchronous, active low) clears all stream state and loads a hop size of 200
// and energy_limit 42949673; stream state also clears after a last_sample word.
module energy_voice_activity_detector_top #(
    parameter int COUNT_BITS = 32,
    parameter int HOP_BITS   = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  evad_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output evad_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [evad_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [evad_pkg::LIMIT_W-1:0]       i_cfg_data
);
    import evad_pkg::*;

    localparam int EW = SQ_W + HOP_BITS;

    logic [HOP_REG_W-1:0]  r_hop;
    logic [LIMIT_W-1:0]    r_limit;
    logic [HOP_REG_W-1:0]  hop_eff;

    t_blk_ctl              blk_ctl;
    logic [EW-1:0]         blk_energy;
    logic [COUNT_BITS-1:0] blk_index;
    logic [COUNT_BITS-1:0] seen;
    logic                  adv;

    assign o_cfg_ready = 1'b1;
    assign hop_eff     = (r_hop == '0) ? HOP_REG_W'(1) : r_hop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop   <= HOP_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HOP_SIZE:     r_hop   <= i_cfg_data[HOP_REG_W-1:0];
                CFG_ENERGY_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    evad_blk_acc #(
        .COUNT_BITS (COUNT_BITS),
        .HOP_BITS   (HOP_BITS)
    ) u_blk_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_hop        (hop_eff),
        .i_adv        (adv),
        .o_ctl        (blk_ctl),
        .o_blk_energy (blk_energy),
        .o_blk_index  (blk_index),
        .o_seen       (seen)
    );

    evad_seg #(
        .COUNT_BITS (COUNT_BITS),
        .HOP_BITS   (HOP_BITS)
    ) u_seg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (blk_ctl),
        .i_blk_energy (blk_energy),
        .i_blk_index  (blk_index),
        .i_seen       (seen),
        .i_hop        (hop_eff),
        .i_limit      (r_limit),
        .o_adv        (adv),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule

@@ test/energy_voice_activity_detector_top_test.sv @@
// Testbench for the energy voice activity detector: predicted segments checked word by word.
`timescale 1ns / 100ps

module energy_voice_activity_detector_top_test;
    import evad_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_word             in_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_word            out_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0]   cfg_data = '0;

    energy_voice_activity_detector_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // detector state as seen by the predictor
    logic [HOP_REG_W-1:0] hop_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [63:0]          prev_blk_nrg;
    logic [63:0]          cur_blk_nrg;
    logic [HOP_REG_W-1:0] blk_pos;
    logic [31:0]          blk_count;
    logic [31:0]          sample_count;
    bit                   seg_open;
    logic [31:0]          seg_begin;

    t_out_word expected_segments[$];

    int  errors = 0;
    int  words_sent = 0;
    int  segments_seen = 0;
    int  reg_writes = 0;
    bit  in_fast = 1'b0;
    bit  out_fast = 1'b0;

    function automatic void clear_detector();
        prev_blk_nrg = '0;
        cur_blk_nrg  = '0;
        blk_pos      = '0;
        blk_count    = '0;
        sample_count = '0;
        seg_open     = 1'b0;
        seg_begin    = '0;
    endfunction

    function automatic void advance_detector(input logic signed [15:0] smp, input logic lst);
        logic [HOP_REG_W-1:0] hop;
        logic [63:0]          frame_nrg;
        logic [31:0]          frame_start;
        bit                   have_prev;
        bit                   speech;
        bit                   emitted;
        hop = (hop_reg == 0) ? 12'd1 : hop_reg;
        emitted = 1'b0;
        cur_blk_nrg  = cur_blk_nrg + 64'(longint'(smp) * longint'(smp));
        blk_pos      = blk_pos + 1'b1;
        sample_count = sample_count + 1;
        if (blk_pos >= hop || blk_pos == 0) begin
            have_prev   = (blk_count != 0);
            frame_start = (blk_count - 32'd1) * 32'(hop);
            blk_count   = blk_count + 1;
            if (have_prev) begin
                frame_nrg = prev_blk_nrg + cur_blk_nrg;
                speech = (frame_nrg >= 64'(limit_reg));
                if (speech && !seg_open) begin
                    seg_begin = frame_start;
                    seg_open = 1'b1;
                end else if (!speech && seg_open) begin
                    expected_segments.insert(expected_segments.size(),
                                             {seg_begin, frame_start});
                    emitted = 1'b1;
                    seg_open = 1'b0;
                end
            end
            prev_blk_nrg = cur_blk_nrg;
            cur_blk_nrg  = '0;
            blk_pos      = '0;
        end
        if (lst) begin
            if (seg_open && !emitted) begin
                expected_segments.insert(expected_segments.size(),
                                         {seg_begin, sample_count});
            end
            clear_detector();
        end
    endfunction

    task automatic send_word(input logic signed [15:0] smp, input logic lst);
        int gap;
        if ($urandom_range(0, 19) == 0) begin
            in_fast = !in_fast;
        end
        gap = in_fast ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= {smp, lst};
        do @(posedge clk); while (!in_ready);
        advance_detector(smp, lst);
        words_sent++;
    endtask

    // drop valid, wait for every pending segment, then let the pipeline empty
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_segments.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [LIMIT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HOP_SIZE:     hop_reg = data[HOP_REG_W-1:0];
            CFG_ENERGY_LIMIT: limit_reg = data;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_detector(input logic [HOP_REG_W-1:0] hop, input logic [LIMIT_W-1:0] lim);
        settle_block();
        write_register(CFG_HOP_SIZE, LIMIT_W'(hop));
        write_register(CFG_ENERGY_LIMIT, lim);
    endtask

    function automatic logic signed [15:0] loud_sample();
        int mag;
        if ($urandom_range(0, 15) == 0) begin
            return 16'sh8000;
        end
        mag = $urandom_range(8192, 32767);
        return ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
    endfunction

    function automatic logic signed [15:0] quiet_sample();
        return 16'(int'($urandom_range(0, 511)) - 256);
    endfunction

    // short stream under the reset settings: never judged
    task automatic test_default_config();
        send_word(16'sd12345, 1'b0);
        send_word(-16'sd5, 1'b1);
    endtask

    task automatic test_field_extremes();
        set_detector(12'd1, '0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh0000, 1'b0);
        send_word(16'shffff, 1'b1);
        set_detector(12'd1, {LIMIT_W{1'b1}});
        send_word(16'sh8000, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b1);
    endtask

    task automatic test_zero_hop();
        set_detector(12'd0, 44'd1048576);
        send_word(16'sd1000, 1'b0);
        send_word(16'sd1000, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(16'sd0, 1'b1);
    endtask

    // last word completes a frame: one ending speech, one starting it
    task automatic test_boundary_end();
        set_detector(12'd2, 44'd67108864);
        repeat (4) send_word(16'sd20000, 1'b0);
        repeat (3) send_word(16'sd0, 1'b0);
        send_word(16'sd0, 1'b1);
        send_word(16'sd0, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(-16'sd20000, 1'b0);
        send_word(16'sd20000, 1'b1);
    endtask

    task automatic test_hop_change();
        set_detector(12'd4, 44'd67108864);
        repeat (3) send_word(16'sd20000, 1'b0);
        set_detector(12'd2, 44'd67108864);
        repeat (3) send_word(-16'sd20000, 1'b0);
        send_word(16'sd0, 1'b1);
    endtask

    // largest hop holds a block open, a smaller hop then closes it mid-stream
    task automatic test_largest_hop();
        set_detector(12'd1, 44'd1048576);
        repeat (3) send_word(16'sd20000, 1'b0);
        set_detector(12'd4095, 44'd1048576);
        repeat (60) send_word(16'sd0, 1'b0);
        set_detector(12'd4, 44'd1048576);
        repeat (4) send_word(16'sd0, 1'b0);
        send_word(16'sd0, 1'b1);
        set_detector(12'd4095, '0);
        for (int k = 0; k < 100; k++) begin
            send_word(16'($urandom), k == 99);
        end
    endtask

    task automatic send_random_stream(input int hop_eff);
        int                 n_bursts;
        int                 len;
        bit                 loud;
        bit                 noise;
        logic signed [15:0] stream_q[$];
        noise = ($urandom_range(0, 7) == 0);
        loud = ($urandom_range(0, 1) != 0);
        n_bursts = noise ? 1 : $urandom_range(1, 6);
        for (int b = 0; b < n_bursts; b++) begin
            if (noise) begin
                len = $urandom_range(1, 3 * hop_eff + 2);
            end else begin
                len = hop_eff * $urandom_range(1, 4);
                if ($urandom_range(0, 3) == 0) begin
                    len += $urandom_range(0, hop_eff);
                end
            end
            repeat (len) begin
                stream_q.insert(stream_q.size(),
                                noise ? 16'($urandom) : loud ? loud_sample() : quiet_sample());
            end
            loud = !loud;
        end
        foreach (stream_q[i]) begin
            send_word(stream_q[i], i == stream_q.size() - 1);
        end
    endtask

    task automatic test_random_streams();
        int                   start_count;
        int                   hop_eff;
        logic [HOP_REG_W-1:0] hop;
        logic [LIMIT_W-1:0]   lim;
        start_count = words_sent;
        while (words_sent - start_count < 700) begin
            case ($urandom_range(0, 5))
                0: hop = 12'd0;
                1: hop = 12'($urandom_range(1, 2));
                2, 3: hop = 12'($urandom_range(3, 8));
                default: hop = 12'($urandom_range(9, 24));
            endcase
            hop_eff = (hop == 0) ? 1 : hop;
            if ($urandom_range(0, 7) == 0) begin
                lim = LIMIT_W'({$urandom, $urandom});
            end else begin
                lim = LIMIT_W'(hop_eff) << $urandom_range(16, 27);
            end
            set_detector(hop, lim);
            repeat ($urandom_range(2, 4)) send_random_stream(hop_eff);
        end
    endtask

    initial begin : result_ready
        int gap;
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                out_fast = !out_fast;
            end
            gap = out_fast ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            segments_seen++;
            if (expected_segments.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected segment word: start %0d end %0d",
                             out_word.segment_start, out_word.segment_end);
                end
            end else begin
                want = expected_segments.pop_front();
                if (want.segment_start !== out_word.segment_start ||
                    want.segment_end !== out_word.segment_end) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("segment mismatch: expected start %0d end %0d, got start %0d end %0d",
                                 want.segment_start, want.segment_end,
                                 out_word.segment_start, out_word.segment_end);
                    end
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        hop_reg   = HOP_RESET;
        limit_reg = LIMIT_RESET;
        clear_detector();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_config();
        test_field_extremes();
        test_zero_hop();
        test_boundary_end();
        test_hop_change();
        test_largest_hop();
        test_random_streams();
        settle_block();
        repeat (8) @(posedge clk);
        $display("run covered %0d sample words and %0d segment words", words_sent, segments_seen);
        $display("across %0d register writes, hop sizes 0 to 4095, limits 0 to full scale",
                 reg_writes);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/evad_pkg.sv
rtl/evad_blk_acc.sv
rtl/evad_seg.sv
rtl/energy_voice_activity_detector_top.sv
test/energy_voice_activity_detector_top_test.sv
